/* rtl/core/sorted_timer_tick_expiry_unit_defines.svh */
// Assertion macros for the sorted timer tick expiry unit.
// No dependencies; included by the top level only.
`ifndef SORTED_TIMER_TICK_EXPIRY_UNIT_DEFINES_SVH
`define SORTED_TIMER_TICK_EXPIRY_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define STTE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define STTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define STTE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define STTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/stte_pkg.sv */
// Shared types and constants for the sorted timer tick expiry unit.
// No dependencies.
`timescale 1ns / 1ps
package stte_pkg;

    localparam int DEF_MAX_TIMERS = 16;
    localparam int MAX_RESULTS    = 16;
    localparam int RES_CNT_W      = $clog2(MAX_RESULTS + 1);
    localparam int TICK_W         = 32;
    localparam int MSG_W          = 16;
    localparam int QUEUE_W        = 4;
    localparam int KIND_W         = 2;

    localparam logic [TICK_W-1:0] NO_DEADLINE = 32'hffff_ffff;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ARM  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_EXPIRY   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ARM_OK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ARM_FULL = 2'd2;

    typedef struct packed {
        logic [TICK_W-1:0]  deadline;
        logic [MSG_W-1:0]   message;
        logic [QUEUE_W-1:0] queue_id;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK_CHK,
        S_EXP_RD,
        S_EXP_CHK,
        S_INS_RD,
        S_INS_CHK,
        S_ARM_OK,
        S_ARM_FULL
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept_tick;
        logic accept_arm;
        logic rd_ins;
        logic exp_take;
        logic exp_done;
        logic ins_shift;
        logic ins_place;
        logic emit_ok;
        logic emit_full;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic tick_pass;
        logic due;
        logic pend_valid;
        logic out_free;
        logic shift_more;
    } t_sts;

endpackage

/* rtl/core/sorted_timer_tick_expiry_unit.sv */
// Top level of the sorted timer tick expiry unit.
// Depends on stte_pkg, stte_ctrl, stte_dp and the assertion macro header.
`timescale 1ns / 1ps
`include "sorted_timer_tick_expiry_unit_defines.svh"
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one word: a tick
//   (opcode 0) or an arm request (opcode 1) with deadline, message, queue.
//   Output channel (o_out_valid / i_out_ready) returns result words; o_last
//   marks the final word caused by one input word. A tick with nothing due
//   returns no word.
//   One input word is processed at a time; o_in_ready is high only while idle.
//   A tick with nothing due ends after the tick check. A tick with expiries
//   walks the table, reading each entry from the timer memory (registered
//   read port) and then checking it. An arm moves each later-deadline timer
//   one slot back, one memory read and one write per moved entry.
//   Full table: an arm is answered with kind 2.
//   Results pass through a one-word output register; while the receiver
//   stalls, the expiry walk holds its place and no word is lost.
//   Reset clears the tick count, the timer count and the nearest deadline
//   (all ones); the timer memory needs no clearing.
module sorted_timer_tick_expiry_unit #(
    parameter int MAX_TIMERS = stte_pkg::DEF_MAX_TIMERS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_opcode,
    input  logic [stte_pkg::TICK_W-1:0]     i_deadline,
    input  logic [stte_pkg::MSG_W-1:0]      i_message,
    input  logic [stte_pkg::QUEUE_W-1:0]    i_queue_id,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [stte_pkg::KIND_W-1:0]     o_kind,
    output logic [stte_pkg::QUEUE_W-1:0]    o_dest_queue,
    output logic [stte_pkg::MSG_W-1:0]      o_payload,
    output logic                            o_last
);
    import stte_pkg::*;

    t_cmd cmd;
    t_sts sts;

    stte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    stte_dp #(
        .MAX_TIMERS (MAX_TIMERS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_deadline   (i_deadline),
        .i_message    (i_message),
        .i_queue_id   (i_queue_id),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_dest_queue (o_dest_queue),
        .o_payload    (o_payload),
        .o_last       (o_last)
    );

    `STTE_ASSERT_IMPL(a_arm_word_last, i_clk, i_rst_n, o_out_valid && (o_kind != KIND_EXPIRY), o_last)
    `STTE_ASSERT_IMPL(a_no_insert_full, i_clk, i_rst_n, cmd.ins_place, !sts.full)
    `STTE_ASSERT_IMPL(a_take_needs_room, i_clk, i_rst_n, cmd.exp_take && sts.pend_valid, sts.out_free)

endmodule

/* rtl/core/stte_ctrl.sv */
// Sequencing state machine for the sorted timer tick expiry unit.
// Depends on stte_pkg; drives the datapath through t_cmd.
`timescale 1ns / 1ps
module stte_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_opcode,
    output logic            o_in_ready,
    input  stte_pkg::t_sts  i_sts,
    output stte_pkg::t_cmd  o_cmd
);
    import stte_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_opcode == OP_ARM) begin
                        if (i_sts.full) begin
                            n_state = S_ARM_FULL;
                        end else begin
                            o_cmd.accept_arm = 1'b1;
                            n_state          = S_INS_RD;
                        end
                    end else begin
                        o_cmd.accept_tick = 1'b1;
                        n_state           = S_TICK_CHK;
                    end
                end
            end
            S_TICK_CHK: begin
                n_state = i_sts.tick_pass ? S_IDLE : S_EXP_RD;
            end
            S_EXP_RD: begin
                n_state = S_EXP_CHK;
            end
            S_EXP_CHK: begin
                // a held word goes out only once the next entry shows whether it is last
                if (!i_sts.pend_valid || i_sts.out_free) begin
                    if (i_sts.due) begin
                        o_cmd.exp_take = 1'b1;
                        n_state        = S_EXP_RD;
                    end else begin
                        o_cmd.exp_done = 1'b1;
                        n_state        = S_IDLE;
                    end
                end
            end
            S_INS_RD: begin
                o_cmd.rd_ins = 1'b1;
                n_state      = S_INS_CHK;
            end
            S_INS_CHK: begin
                if (i_sts.shift_more) begin
                    o_cmd.ins_shift = 1'b1;
                    n_state         = S_INS_RD;
                end else begin
                    o_cmd.ins_place = 1'b1;
                    n_state         = S_ARM_OK;
                end
            end
            S_ARM_OK: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_ok = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_ARM_FULL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_full = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/stte_dp.sv */
// Datapath: tick count, circular timer memory, pending and output words.
// Depends on stte_pkg; controlled by stte_ctrl through t_cmd.
`timescale 1ns / 1ps
module stte_dp #(
    parameter int MAX_TIMERS = stte_pkg::DEF_MAX_TIMERS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [stte_pkg::TICK_W-1:0]     i_deadline,
    input  logic [stte_pkg::MSG_W-1:0]      i_message,
    input  logic [stte_pkg::QUEUE_W-1:0]    i_queue_id,
    input  stte_pkg::t_cmd                  i_cmd,
    output stte_pkg::t_sts                  o_sts,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [stte_pkg::KIND_W-1:0]     o_kind,
    output logic [stte_pkg::QUEUE_W-1:0]    o_dest_queue,
    output logic [stte_pkg::MSG_W-1:0]      o_payload,
    output logic                            o_last
);
    import stte_pkg::*;

    localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CW = $clog2(MAX_TIMERS + 1);
    localparam logic [IW:0]   MAX_L    = (IW+1)'(MAX_TIMERS);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TIMERS - 1);
    localparam logic [CW-1:0] MAX_C    = CW'(MAX_TIMERS);
    localparam logic [RES_CNT_W-1:0] RES_LIM = RES_CNT_W'(MAX_RESULTS);

    t_entry mem [MAX_TIMERS];

    logic [TICK_W-1:0]    r_tick;
    logic [TICK_W-1:0]    r_next;
    logic [CW-1:0]        r_active;
    logic [IW-1:0]        r_head;
    logic [IW-1:0]        r_j;
    logic [RES_CNT_W-1:0] r_n;
    t_entry               r_arg;
    t_entry               r_rd;
    logic                 r_pend_valid;
    t_entry               r_pend;
    logic                 r_out_valid;
    logic [KIND_W-1:0]    r_kind;
    logic [QUEUE_W-1:0]   r_queue;
    logic [MSG_W-1:0]     r_payload;
    logic                 r_last;

    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic          wr_en;
    t_entry        wr_data;
    logic          out_free;
    logic          out_load;
    logic          due;

    // logical slot to memory address, head-relative with wrap
    function automatic logic [IW-1:0] phys(input logic [IW-1:0] head,
                                           input logic [IW-1:0] slot);
        logic [IW:0] sum;
        sum = {1'b0, head} + {1'b0, slot};
        if (sum >= MAX_L) begin
            sum = sum - MAX_L;
        end
        return sum[IW-1:0];
    endfunction

    assign out_free = !r_out_valid || i_out_ready;
    assign out_load = ((i_cmd.exp_take || i_cmd.exp_done) && r_pend_valid) ||
                      i_cmd.emit_ok || i_cmd.emit_full;
    assign due      = (r_active != '0) && (r_n < RES_LIM) && (r_rd.deadline <= r_tick);
    assign rd_addr  = i_cmd.rd_ins ? phys(r_head, r_j - 1'b1) : r_head;
    assign wr_addr  = phys(r_head, r_j);
    assign wr_en    = i_cmd.ins_shift || i_cmd.ins_place;
    assign wr_data  = i_cmd.ins_shift ? r_rd : r_arg;

    always_comb begin
        o_sts            = '0;
        o_sts.full       = (r_active == MAX_C);
        o_sts.tick_pass  = (r_next > r_tick);
        o_sts.due        = due;
        o_sts.pend_valid = r_pend_valid;
        o_sts.out_free   = out_free;
        o_sts.shift_more = (r_j != '0) && (r_rd.deadline > r_arg.deadline);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick       <= '0;
            r_next       <= NO_DEADLINE;
            r_active     <= '0;
            r_head       <= '0;
            r_j          <= '0;
            r_n          <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.accept_tick) begin
                r_tick       <= r_tick + 1'b1;
                r_n          <= '0;
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.accept_arm) begin
                r_j <= r_active[IW-1:0];
            end
            if (i_cmd.exp_take) begin
                r_pend_valid <= 1'b1;
                r_head       <= (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
                r_active     <= r_active - 1'b1;
                r_n          <= r_n + 1'b1;
            end
            if (i_cmd.exp_done) begin
                r_pend_valid <= 1'b0;
                r_next       <= (r_active != '0) ? r_rd.deadline : NO_DEADLINE;
            end
            if (i_cmd.ins_shift) begin
                r_j <= r_j - 1'b1;
            end
            if (i_cmd.ins_place) begin
                r_active <= r_active + 1'b1;
                if (r_j == '0) begin
                    r_next <= r_arg.deadline;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_arm) begin
            r_arg.deadline <= i_deadline;
            r_arg.message  <= i_message;
            r_arg.queue_id <= i_queue_id;
        end
        if (i_cmd.exp_take) begin
            r_pend <= r_rd;
        end
        if ((i_cmd.exp_take || i_cmd.exp_done) && r_pend_valid) begin
            r_kind    <= KIND_EXPIRY;
            r_queue   <= r_pend.queue_id;
            r_payload <= r_pend.message;
            r_last    <= i_cmd.exp_done;
        end
        if (i_cmd.emit_ok || i_cmd.emit_full) begin
            r_kind    <= i_cmd.emit_ok ? KIND_ARM_OK : KIND_ARM_FULL;
            r_queue   <= '0;
            r_payload <= '0;
            r_last    <= 1'b1;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_dest_queue = r_queue;
    assign o_payload    = r_payload;
    assign o_last       = r_last;

endmodule

/* tb/sv/sorted_timer_tick_expiry_unit_test.sv */
// Testbench for the sorted timer tick expiry unit: directed and random ticks and arms,
// each result word checked against an in-bench model of the sorted timer list.
// Depends on stte_pkg and the sorted_timer_tick_expiry_unit RTL.
`timescale 1ns / 1ps
module sorted_timer_tick_expiry_unit_test;
    import stte_pkg::*;

    localparam int TIMER_SLOTS = DEF_MAX_TIMERS;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [QUEUE_W-1:0] dest_queue;
        logic [MSG_W-1:0]   payload;
        logic               last;
    } t_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_opcode;
    logic [TICK_W-1:0]  i_deadline;
    logic [MSG_W-1:0]   i_message;
    logic [QUEUE_W-1:0] i_queue_id;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [KIND_W-1:0]  o_kind;
    logic [QUEUE_W-1:0] o_dest_queue;
    logic [MSG_W-1:0]   o_payload;
    logic               o_last;

    // model of the timer list
    t_entry            timer_list [TIMER_SLOTS];
    logic [TICK_W-1:0] tick_now;
    logic [TICK_W-1:0] nearest_deadline;
    int                armed_count;

    t_result expected_words [$];
    t_result oldest_word;
    int      error_count;
    int      words_sent;
    int      send_idle_pct;
    int      recv_stall_pct;

    sorted_timer_tick_expiry_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_deadline   (i_deadline),
        .i_message    (i_message),
        .i_queue_id   (i_queue_id),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_dest_queue (o_dest_queue),
        .o_payload    (o_payload),
        .o_last       (o_last)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
        error_count++;
    endtask

    // Applies one accepted word to the timer list and queues the words it causes.
    task automatic predict_timer_words(input logic op, input logic [TICK_W-1:0] dl,
                                       input logic [MSG_W-1:0] msg,
                                       input logic [QUEUE_W-1:0] q);
        int      pos;
        int      n;
        t_result word;
        word = '0;
        word.last = 1'b1;
        if (op == OP_ARM) begin
            if (armed_count >= TIMER_SLOTS) begin
                word.kind = KIND_ARM_FULL;
            end else begin
                pos = 0;
                while (pos < armed_count && timer_list[pos].deadline <= dl)
                    pos++;
                for (int j = armed_count; j > pos; j--)
                    timer_list[j] = timer_list[j-1];
                timer_list[pos].deadline = dl;
                timer_list[pos].message  = msg;
                timer_list[pos].queue_id = q;
                armed_count++;
                nearest_deadline = timer_list[0].deadline;
                word.kind = KIND_ARM_OK;
            end
            expected_words.push_back(word);
        end else begin
            tick_now = tick_now + 1;
            if (nearest_deadline <= tick_now) begin
                n = 0;
                while (n < armed_count && n < MAX_RESULTS && timer_list[n].deadline <= tick_now)
                    n++;
                for (int j = 0; j < n; j++) begin
                    word.kind       = KIND_EXPIRY;
                    word.dest_queue = timer_list[j].queue_id;
                    word.payload    = timer_list[j].message;
                    word.last       = (j == n - 1);
                    expected_words.push_back(word);
                end
                armed_count -= n;
                for (int j = 0; j < armed_count; j++)
                    timer_list[j] = timer_list[j+n];
                nearest_deadline = (armed_count > 0) ? timer_list[0].deadline : NO_DEADLINE;
            end
        end
    endtask

    task automatic send_word(input logic op, input logic [TICK_W-1:0] dl,
                             input logic [MSG_W-1:0] msg, input logic [QUEUE_W-1:0] q);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_deadline <= dl;
        i_message  <= msg;
        i_queue_id <= q;
        do @(posedge i_clk); while (!o_in_ready);
        predict_timer_words(op, dl, msg, q);
        words_sent++;
    endtask

    task automatic send_tick();
        send_word(OP_TICK, $urandom, 16'($urandom), 4'($urandom));
    endtask

    task automatic send_arm_near(input int lo, input int hi);
        send_word(OP_ARM, tick_now + $urandom_range(lo, hi), 16'($urandom), 4'($urandom));
    endtask

    // receiver side
    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word, kind", 0, 32'(o_kind));
            end else begin
                oldest_word = expected_words.pop_front();
                if (o_kind !== oldest_word.kind)
                    report_mismatch("kind", 32'(oldest_word.kind), 32'(o_kind));
                if (o_dest_queue !== oldest_word.dest_queue)
                    report_mismatch("dest_queue", 32'(oldest_word.dest_queue),
                                    32'(o_dest_queue));
                if (o_payload !== oldest_word.payload)
                    report_mismatch("payload", 32'(oldest_word.payload), 32'(o_payload));
                if (o_last !== oldest_word.last)
                    report_mismatch("last", 32'(oldest_word.last), 32'(o_last));
            end
        end
    end

    task automatic test_tick_nothing_due();
        send_tick();
    endtask

    // Mixed deadlines 0..2 with repeats: sorted insert, equal-deadline order,
    // a past deadline, then one arm too many.
    task automatic test_fill_until_full();
        for (int i = 0; i <= TIMER_SLOTS; i++)
            send_word(OP_ARM, (i * 7) % 3, 16'(16'hA5A5 ^ (16'h1111 * i)), 4'(i));
    endtask

    // Whole table due on one tick, then a tick on an empty table.
    task automatic test_expire_everything();
        send_tick();
        send_tick();
    endtask

    // Field extremes; the all-ones deadline never expires and keeps one slot.
    task automatic test_field_extremes();
        send_word(OP_ARM, 32'hffff_ffff, 16'hffff, 4'hf);
        send_word(OP_ARM, 32'h0, 16'h0, 4'h0);
        send_tick();
    endtask

    task automatic test_drain_pause();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_random_traffic(input int items, input int idle_pct,
                                       input int stall_pct);
        int start;
        int pick;
        int count;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start = words_sent;
        while (words_sent - start < items) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                count = $urandom_range(1, 4);
                repeat (count) send_arm_near(0, 10);
                count = $urandom_range(1, 6);
                repeat (count) send_tick();
            end else if (pick == 6) begin
                // arm burst close together, usually runs into a full table
                count = $urandom_range(10, 18);
                repeat (count) send_arm_near(1, 3);
                count = $urandom_range(3, 5);
                repeat (count) send_tick();
            end else if (pick == 7) begin
                send_word(OP_ARM, $urandom_range(0, tick_now), 16'($urandom), 4'($urandom));
                send_tick();
            end else begin
                send_word(1'($urandom), tick_now + $urandom_range(0, 40),
                          16'($urandom), 4'($urandom));
            end
        end
    endtask

    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_opcode         = OP_TICK;
        i_deadline       = '0;
        i_message        = '0;
        i_queue_id       = '0;
        i_out_ready      = 1'b0;
        error_count      = 0;
        words_sent       = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        tick_now         = '0;
        nearest_deadline = NO_DEADLINE;
        armed_count      = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_tick_nothing_due();
        test_fill_until_full();
        test_expire_everything();
        test_field_extremes();

        test_random_traffic(62, 0, 0);
        test_drain_pause();
        test_random_traffic(62, 81, 0);
        test_random_traffic(62, 0, 81);
        test_random_traffic(62, 36, 36);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
